FILE: rtl/sclp_pkg.sv
// ----------------------------------------------------------------------------
// sclp_pkg
// Shared types, command table and event codes for the serial command line
// parser.
// ----------------------------------------------------------------------------
package sclp_pkg;

   // ASCII characters with a special meaning
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'd32;

   // Event codes reported with each echoed byte
   localparam logic [3:0] EV_NONE     = 4'd0;
   localparam logic [3:0] EV_IGNORED  = 4'd1;
   localparam logic [3:0] EV_HELP     = 4'd2;
   localparam logic [3:0] EV_LED_ON   = 4'd3;
   localparam logic [3:0] EV_LED_OFF  = 4'd4;
   localparam logic [3:0] EV_TOGGLED  = 4'd5;
   localparam logic [3:0] EV_STATUS   = 4'd6;
   localparam logic [3:0] EV_TOO_LONG = 4'd7;
   localparam logic [3:0] EV_UNKNOWN  = 4'd8;

   // Command table
   localparam int NUM_CMDS    = 5;
   localparam int CMD_LEN_MAX = 10;
   localparam int CMD_BITS    = 8 * CMD_LEN_MAX;

   // Text is right-aligned: the last character sits in the low byte
   localparam logic [CMD_BITS-1:0] CMD_TEXT [NUM_CMDS] = '{
      CMD_BITS'("HELP"),
      CMD_BITS'("LED ON"),
      CMD_BITS'("LED OFF"),
      CMD_BITS'("LED TOGGLE"),
      CMD_BITS'("STATUS")
   };
   localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{4'd4, 4'd6, 4'd7, 4'd10, 4'd6};
   localparam logic [3:0] CMD_EVENT [NUM_CMDS] =
      '{EV_HELP, EV_LED_ON, EV_LED_OFF, EV_TOGGLED, EV_STATUS};

   // Matcher result handed to the line control
   typedef struct packed {
      logic [NUM_CMDS-1:0] match_next;  // commands still possible after this char
      logic                hit;         // finished line equals a command
      logic [3:0]          cmd_event;   // event of that command
   } match_res_type;

   // One result beat
   typedef struct packed {
      logic [7:0] echo_byte;
      logic [3:0] event_res;
      logic       led_on;
   } rsp_beat_type;

   // Character idx (from the left) of command cmd; zero past its end
   function automatic logic [7:0] cmd_char(input int cmd, input logic [3:0] idx);
      logic [CMD_BITS-1:0] text;
      int                  pos;
      text = CMD_TEXT[cmd];
      pos  = int'(CMD_LEN[cmd]) - 1 - int'(idx);
      if (idx < CMD_LEN[cmd]) begin
         return text[8*pos +: 8];
      end
      return 8'h00;
   endfunction

   // Fold a-z to upper case, leave all else
   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         return c - CASE_DIFF;
      end
      return c;
   endfunction

endpackage

FILE: rtl/sclp_if.sv
// ----------------------------------------------------------------------------
// sclp_req_if / sclp_rsp_if
// Valid/ready channels carrying received bytes in and parse results out.
// ----------------------------------------------------------------------------
interface sclp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sclp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] echo_byte;
   logic [3:0] event_res;
   logic       led_on;

   modport source (output valid, output echo_byte, output event_res, output led_on,
                   input ready);
   modport sink   (input valid, input echo_byte, input event_res, input led_on,
                   output ready);
endinterface

FILE: rtl/sclp_matcher.sv
// ----------------------------------------------------------------------------
// sclp_matcher
// Per-character command compare and end-of-line command lookup.
// ----------------------------------------------------------------------------
module sclp_matcher #(
   parameter int CNT_W = 6
) (
   input  logic [7:0]                   char_in,
   input  logic [CNT_W-1:0]             char_count,
   input  logic [sclp_pkg::NUM_CMDS-1:0] match_cur,
   output sclp_pkg::match_res_type      res
);

   logic [7:0] upper;
   logic       idx_ok;
   logic [3:0] idx;

   assign upper  = sclp_pkg::fold_upper(char_in);
   assign idx_ok = char_count < CNT_W'(sclp_pkg::CMD_LEN_MAX);
   assign idx    = idx_ok ? char_count[3:0] : 4'd0;

   // drop every command that this character rules out; look up a finished match
   always_comb begin
      res.match_next = match_cur;
      res.hit        = 1'b0;
      res.cmd_event  = sclp_pkg::EV_UNKNOWN;
      for (int i = 0; i < sclp_pkg::NUM_CMDS; i++) begin
         if (!idx_ok || idx >= sclp_pkg::CMD_LEN[i] ||
             sclp_pkg::cmd_char(i, idx) != upper) begin
            res.match_next[i] = 1'b0;
         end
      end
      for (int i = sclp_pkg::NUM_CMDS - 1; i >= 0; i--) begin
         if (match_cur[i] && char_count == CNT_W'(sclp_pkg::CMD_LEN[i])) begin
            res.hit       = 1'b1;
            res.cmd_event = sclp_pkg::CMD_EVENT[i];
         end
      end
   end

endmodule

FILE: rtl/sclp_line_ctrl.sv
// ----------------------------------------------------------------------------
// sclp_line_ctrl
// Line state, comment detection and LED bit; produces one result per byte.
// ----------------------------------------------------------------------------
module sclp_line_ctrl #(
   parameter int LINE_MAX = 64,
   parameter int CNT_W    = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [7:0]              char_in,
   output sclp_pkg::rsp_beat_type  beat_out
);

   logic                          in_line_ff, in_line_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [sclp_pkg::NUM_CMDS-1:0] match_ff, match_in;
   logic                          comment_ff, comment_in;
   logic                          slash_ff, slash_in;
   logic                          led_ff, led_in;

   logic                          term;
   logic [CNT_W-1:0]              base_count;
   logic [sclp_pkg::NUM_CMDS-1:0] base_match;
   logic                          base_comment;
   logic                          base_slash;
   logic [3:0]                    ev;
   sclp_pkg::match_res_type       mres;

   assign term = (char_in == sclp_pkg::CHAR_CR) || (char_in == sclp_pkg::CHAR_LF);

   // a new line starts from cleared line state
   assign base_count   = in_line_ff ? count_ff : '0;
   assign base_match   = in_line_ff ? match_ff : '1;
   assign base_comment = in_line_ff ? comment_ff : 1'b0;
   assign base_slash   = in_line_ff ? slash_ff : 1'b0;

   sclp_matcher #(
      .CNT_W (CNT_W)
   ) u_matcher (
      .char_in    (char_in),
      .char_count (base_count),
      .match_cur  (base_match),
      .res        (mres)
   );

   // next line state and event for this byte
   always_comb begin
      in_line_in = in_line_ff;
      count_in   = count_ff;
      match_in   = match_ff;
      comment_in = comment_ff;
      slash_in   = slash_ff;
      led_in     = led_ff;
      ev         = sclp_pkg::EV_NONE;

      if ((!in_line_ff && !term) ||
          (in_line_ff && !term && count_ff < CNT_W'(LINE_MAX - 1))) begin
         // take the character into the line
         in_line_in = 1'b1;
         count_in   = base_count + 1'b1;
         match_in   = mres.match_next;
         comment_in = base_comment;
         slash_in   = base_slash;
         if (base_count == '0) begin
            comment_in = (char_in == sclp_pkg::CHAR_HASH);
            slash_in   = (char_in == sclp_pkg::CHAR_SLASH);
         end else if (base_count == CNT_W'(1)) begin
            comment_in = base_comment | (base_slash && char_in == sclp_pkg::CHAR_SLASH);
         end
      end else if (in_line_ff) begin
         // close the line: terminator or overflow
         in_line_in = 1'b0;
         count_in   = '0;
         match_in   = '1;
         comment_in = 1'b0;
         slash_in   = 1'b0;
         if (!term) begin
            ev = sclp_pkg::EV_TOO_LONG;
         end else if (comment_ff) begin
            ev = sclp_pkg::EV_IGNORED;
         end else if (mres.hit) begin
            ev = mres.cmd_event;
            case (mres.cmd_event)
               sclp_pkg::EV_LED_ON:  led_in = 1'b1;
               sclp_pkg::EV_LED_OFF: led_in = 1'b0;
               sclp_pkg::EV_TOGGLED: led_in = !led_ff;
               default:              led_in = led_ff;
            endcase
         end else begin
            ev = sclp_pkg::EV_UNKNOWN;
         end
      end
   end

   // advance state once per accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_line_ff <= 1'b0;
         count_ff   <= '0;
         match_ff   <= '1;
         comment_ff <= 1'b0;
         slash_ff   <= 1'b0;
         led_ff     <= 1'b0;
      end else if (advance) begin
         in_line_ff <= in_line_in;
         count_ff   <= count_in;
         match_ff   <= match_in;
         comment_ff <= comment_in;
         slash_ff   <= slash_in;
         led_ff     <= led_in;
      end
   end

   assign beat_out.echo_byte = char_in;
   assign beat_out.event_res = ev;
   assign beat_out.led_on    = led_in;

endmodule

FILE: rtl/serial_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// serial_command_line_parser_core
// Echoes received bytes, assembles command lines and reports line events.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  req_if  | in        | rx_byte
//  rsp_if  | out       | echo_byte, event_res, led_on
//
// Every byte gives exactly one result beat. Input register, then line control
// and command compare, then result register; one byte per cycle is sustained
// while the receiver keeps ready high.
// Synchronous active-high reset clears line state, the LED bit and both stages.
// A stalled result holds in the result register; the input stage keeps
// accepting while the result register empties in the same cycle.
// ----------------------------------------------------------------------------
module serial_command_line_parser_core #(
   parameter int LINE_MAX = 64
) (
   input  logic         clock,
   input  logic         reset,
   sclp_req_if.sink     req_if,
   sclp_rsp_if.source   rsp_if
);

   localparam int CNT_W = $clog2(LINE_MAX);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff;
   sclp_pkg::rsp_beat_type out_beat_ff;
   sclp_pkg::rsp_beat_type beat;
   logic                   advance;

   // move the held byte into the result register when it is free
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   sclp_line_ctrl #(
      .LINE_MAX (LINE_MAX),
      .CNT_W    (CNT_W)
   ) u_line_ctrl (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .char_in  (in_byte_ff),
      .beat_out (beat)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_beat_ff <= beat;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.echo_byte = out_beat_ff.echo_byte;
   assign rsp_if.event_res = out_beat_ff.event_res;
   assign rsp_if.led_on    = out_beat_ff.led_on;

endmodule

FILE: verif/sclp_line_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sclp_line_checker
// Watches both channels of the command line parser, predicts the echo, event
// and LED bit of every accepted byte, and compares each result beat in order.
// ----------------------------------------------------------------------------
module sclp_line_checker #(
   parameter int LINE_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   sclp_req_if         req_if,
   sclp_rsp_if         rsp_if,
   output int unsigned mismatch_count,
   output int unsigned beats_pending
);

   // Command words and the event each one reports
   string      cmd_words [sclp_pkg::NUM_CMDS] =
      '{"HELP", "LED ON", "LED OFF", "LED TOGGLE", "STATUS"};
   logic [3:0] cmd_codes [sclp_pkg::NUM_CMDS] =
      '{sclp_pkg::EV_HELP, sclp_pkg::EV_LED_ON, sclp_pkg::EV_LED_OFF,
        sclp_pkg::EV_TOGGLED, sclp_pkg::EV_STATUS};

   // Predicted parser state
   logic                          line_open;
   int                            line_len;
   logic [sclp_pkg::NUM_CMDS-1:0] cmd_alive;
   logic                          is_comment;
   logic                          lead_slash;
   logic                          lamp;

   sclp_pkg::rsp_beat_type        pending_beats [$];

   // Clear the per-line state
   function automatic void start_line();
      line_len   = 0;
      cmd_alive  = '1;
      is_comment = 1'b0;
      lead_slash = 1'b0;
   endfunction

   // Add one character: narrow the candidate commands, spot comment markers
   function automatic void take_char(input logic [7:0] c);
      logic [7:0] up;
      up = (c >= sclp_pkg::CHAR_LOW_A && c <= sclp_pkg::CHAR_LOW_Z) ?
           c - sclp_pkg::CASE_DIFF : c;
      for (int i = 0; i < sclp_pkg::NUM_CMDS; i++) begin
         if (line_len >= cmd_words[i].len()) begin
            cmd_alive[i] = 1'b0;
         end else if (cmd_words[i][line_len] != up) begin
            cmd_alive[i] = 1'b0;
         end
      end
      if (line_len == 0) begin
         if (c == sclp_pkg::CHAR_HASH) begin
            is_comment = 1'b1;
         end
         lead_slash = (c == sclp_pkg::CHAR_SLASH);
      end else if (line_len == 1) begin
         if (lead_slash && c == sclp_pkg::CHAR_SLASH) begin
            is_comment = 1'b1;
         end
      end
      line_len++;
   endfunction

   // Classify a finished line and apply its effect on the LED
   function automatic logic [3:0] close_line();
      if (is_comment) begin
         return sclp_pkg::EV_IGNORED;
      end
      for (int i = 0; i < sclp_pkg::NUM_CMDS; i++) begin
         if (cmd_alive[i] && line_len == cmd_words[i].len()) begin
            case (cmd_codes[i])
               sclp_pkg::EV_LED_ON:  lamp = 1'b1;
               sclp_pkg::EV_LED_OFF: lamp = 1'b0;
               sclp_pkg::EV_TOGGLED: lamp = !lamp;
               default: ;
            endcase
            return cmd_codes[i];
         end
      end
      return sclp_pkg::EV_UNKNOWN;
   endfunction

   // Advance the predicted parser by one received byte
   function automatic sclp_pkg::rsp_beat_type parse_byte(input logic [7:0] c);
      sclp_pkg::rsp_beat_type beat;
      logic                   ends;
      ends           = (c == sclp_pkg::CHAR_CR || c == sclp_pkg::CHAR_LF);
      beat.event_res = sclp_pkg::EV_NONE;
      if (!line_open) begin
         if (!ends) begin
            start_line();
            line_open = 1'b1;
            take_char(c);
         end
      end else if (ends) begin
         beat.event_res = close_line();
         line_open      = 1'b0;
         start_line();
      end else if (line_len < LINE_MAX - 1) begin
         take_char(c);
      end else begin
         // drop the overflowing character and go idle
         beat.event_res = sclp_pkg::EV_TOO_LONG;
         line_open      = 1'b0;
         start_line();
      end
      beat.echo_byte = c;
      beat.led_on    = lamp;
      return beat;
   endfunction

   // Compare result beats first, then queue the prediction for a new byte
   always @(posedge clock) begin
      sclp_pkg::rsp_beat_type want;
      if (reset) begin
         line_open = 1'b0;
         lamp      = 1'b0;
         start_line();
         pending_beats.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_beats.size() == 0) begin
               $error("result beat with no byte outstanding: echo_byte %0d event_res %0d",
                      rsp_if.echo_byte, rsp_if.event_res);
               mismatch_count++;
            end else begin
               want = pending_beats.pop_front();
               if (rsp_if.echo_byte !== want.echo_byte) begin
                  $error("echo_byte: expected %0d, actual %0d",
                         want.echo_byte, rsp_if.echo_byte);
                  mismatch_count++;
               end
               if (rsp_if.event_res !== want.event_res) begin
                  $error("event_res: expected %0d, actual %0d",
                         want.event_res, rsp_if.event_res);
                  mismatch_count++;
               end
               if (rsp_if.led_on !== want.led_on) begin
                  $error("led_on: expected %0d, actual %0d", want.led_on, rsp_if.led_on);
                  mismatch_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            pending_beats.push_back(parse_byte(req_if.rx_byte));
         end
      end
      beats_pending = pending_beats.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives received bytes into the command line parser: a short directed run,
// then phases of random command lines, comments, near misses, overlong lines
// and raw noise under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int LINE_MAX        = 64;
   localparam int NUM_PHASES      = 5;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int HOLD_OFF_CYCLES = 300;
   // longest quiet stretch is the receiver hold-off; allow several times that
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int SEND_IDLE_PCT  [NUM_PHASES] = '{0, 56, 0, 6, 0};
   localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 56, 6, 0};

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned beats_pending;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off_req;
   bit          line_open;
   int          sent_items;
   int          idle_cycles;
   string       cmd_words [sclp_pkg::NUM_CMDS] =
      '{"HELP", "LED ON", "LED OFF", "LED TOGGLE", "STATUS"};

   sclp_req_if req_if ();
   sclp_rsp_if rsp_if ();

   serial_command_line_parser_core #(
      .LINE_MAX (LINE_MAX)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   sclp_line_checker #(
      .LINE_MAX (LINE_MAX)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .mismatch_count (mismatch_count),
      .beats_pending  (beats_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run if no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one byte after random gaps and hold it until accepted
   task automatic send_byte(input logic [7:0] b);
      logic ends;
      ends = (b == sclp_pkg::CHAR_CR || b == sclp_pkg::CHAR_LF);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
      // terminators on an idle line are only echoed
      if (!ends || line_open) begin
         sent_items++;
      end
      line_open = !ends;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) begin
         send_byte(s[k]);
      end
   endtask

   // Drop valid and hold off until every predicted beat has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (beats_pending != 0);
      @(posedge clock);
   endtask

   function automatic logic [7:0] any_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == sclp_pkg::CHAR_CR || c == sclp_pkg::CHAR_LF);
      return c;
   endfunction

   function automatic logic [7:0] text_char();
      return 8'($urandom_range(32, 126));
   endfunction

   function automatic logic [7:0] vary_case(input logic [7:0] c);
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) begin
         return c + sclp_pkg::CASE_DIFF;
      end
      return c;
   endfunction

   // Build and send one random line, nearly half of them commands
   task automatic send_random_line();
      logic [7:0] line_q [$];
      int         pick;
      int         word;
      int         cut;
      bit         terminate;
      pick      = $urandom_range(0, 99);
      word      = $urandom_range(0, sclp_pkg::NUM_CMDS - 1);
      terminate = 1'b1;
      if (pick < 45) begin
         // command in random case, sometimes slightly damaged
         for (int k = 0; k < cmd_words[word].len(); k++) begin
            line_q.push_back(vary_case(cmd_words[word][k]));
         end
         case ($urandom_range(0, 19))
            0, 1: line_q[$urandom_range(0, line_q.size() - 1)] = text_char();
            2:    void'(line_q.pop_back());
            3:    line_q.push_back(text_char());
            default: ;
         endcase
      end else if (pick < 55) begin
         // comment markers and a lone leading slash
         case ($urandom_range(0, 2))
            0: line_q.push_back(sclp_pkg::CHAR_HASH);
            1: begin
               line_q.push_back(sclp_pkg::CHAR_SLASH);
               line_q.push_back(sclp_pkg::CHAR_SLASH);
            end
            default: line_q.push_back(sclp_pkg::CHAR_SLASH);
         endcase
         repeat ($urandom_range(0, 6)) line_q.push_back(text_char());
      end else if (pick < 65) begin
         // proper prefix of a command
         cut = $urandom_range(1, cmd_words[word].len() - 1);
         for (int k = 0; k < cut; k++) begin
            line_q.push_back(vary_case(cmd_words[word][k]));
         end
      end else if (pick < 70) begin
         // lines around the length limit
         repeat ($urandom_range(LINE_MAX - 3, LINE_MAX + 2)) line_q.push_back(any_char());
      end else if (pick < 88) begin
         repeat ($urandom_range(0, 6)) line_q.push_back(any_char());
      end else begin
         // raw noise, terminators included
         repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
         terminate = 1'b0;
      end
      foreach (line_q[k]) begin
         send_byte(line_q[k]);
      end
      if (terminate) begin
         send_byte($urandom_range(0, 1) ? sclp_pkg::CHAR_CR : sclp_pkg::CHAR_LF);
         if ($urandom_range(0, 7) == 0) begin
            send_byte($urandom_range(0, 1) ? sclp_pkg::CHAR_CR : sclp_pkg::CHAR_LF);
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      int phase_end;
      bit hold_done;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_done      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle terminators, comments, short and odd lines, byte extremes
      send_byte(sclp_pkg::CHAR_CR);
      send_byte(sclp_pkg::CHAR_LF);
      send_text("//");
      send_byte(sclp_pkg::CHAR_LF);
      send_text("#");
      send_byte(sclp_pkg::CHAR_CR);
      send_text("hElp");
      send_byte(sclp_pkg::CHAR_CR);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sclp_pkg::CHAR_CR);
      send_text("x");
      send_byte(sclp_pkg::CHAR_LF);
      send_text("Status");
      send_byte(sclp_pkg::CHAR_LF);
      wait_drained();

      // Random phases with different gap and stall mixes
      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct  = SEND_IDLE_PCT[p];
         recv_stall_pct = RECV_STALL_PCT[p];
         phase_end      = sent_items + ITEMS_PER_PHASE;
         while (sent_items < phase_end) begin
            if (!hold_done && sent_items >= phase_end - ITEMS_PER_PHASE / 2) begin
               hold_off_req = 1'b1;
               hold_done    = 1'b1;
            end
            send_random_line();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/sclp_pkg.sv
rtl/sclp_if.sv
rtl/sclp_matcher.sv
rtl/sclp_line_ctrl.sv
rtl/serial_command_line_parser_core.sv
verif/sclp_line_checker.sv
verif/tb.sv
